// ----- design/sliding_window_rate_limiter_assert.svh -----
// Assertion macros used by the checker file of the rate limiter.
`ifndef SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_RATE_LIMITER_ASSERT_SVH

// Clocked property that is not evaluated while reset is high.
`define SWRL_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define SWRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/swrl_pkg.sv -----
`timescale 1ns / 1ps

package swrl_pkg;

   localparam int TABLE_DEPTH = 16;

   localparam int KEY_W     = 32;
   localparam int TIME_W    = 32;
   localparam int LIMIT_W   = 8;
   localparam int WINDOW_W  = 16;
   localparam int VERDICT_W = 2;
   localparam int COUNT_W   = 5;

   // Internal count is wide enough for the whole table and never narrower than the port.
   localparam int CNT_RAW_W = $clog2(TABLE_DEPTH + 1);
   localparam int CNT_W     = (CNT_RAW_W > COUNT_W) ? CNT_RAW_W : COUNT_W;
   localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_LIMIT  = 1'b0;
   localparam logic CSR_IDX_WINDOW = 1'b1;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(3);
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

   typedef logic [VERDICT_W-1:0]   verdict_type;
   typedef logic [TABLE_DEPTH-1:0] slot_mask_type;

   localparam verdict_type VERDICT_ADMITTED = 2'd0;
   localparam verdict_type VERDICT_LIMITED  = 2'd1;
   localparam verdict_type VERDICT_FULL     = 2'd2;

endpackage

// ----- design/sliding_window_rate_limiter.sv -----
`timescale 1ns / 1ps
// Sliding-window rate limiter for connection requests.
// Request channel (req_*): one word carries a client key and the current time in
// seconds. Response channel (rsp_*): one word per request with a verdict
// (admitted, rate limited, table full) and the number of live table entries that
// matched the key before any insert.
// A request is held in an input register; one pass of logic on the held request
// frees expired entries, counts key matches in all slots in parallel, picks the
// lowest free slot and loads the response register when it is empty or not stalled.
// One request per cycle is sustained while the receiver does not stall.
// The table update of one request is visible to the very next one.
// When the receiver stalls, the response register holds its word, the input
// register still takes one more request, and req_stall rises once both are full.
// The APB-style csr_* port sets the request limit (address 0) and the window
// length in seconds (address 4); write them only while no request is in flight.
// Synchronous reset frees every slot, empties both registers and restores a limit
// of 3 and a window of 60 seconds.
module sliding_window_rate_limiter
   import swrl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KEY_W-1:0]        req_client_key,
   input  logic [TIME_W-1:0]       req_now_seconds,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [VERDICT_W-1:0]    rsp_verdict,
   output logic [COUNT_W-1:0]      rsp_recent_count,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic [LIMIT_W-1:0]  limit_ff;
   logic [WINDOW_W-1:0] window_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic [KEY_W-1:0]    s1_key_ff;
   logic [TIME_W-1:0]   s1_now_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         rsp_verdict_ff, rsp_verdict_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   slot_mask_type       slot_valid_ff, slot_valid_in;
   logic [KEY_W-1:0]    slot_key_ff  [TABLE_DEPTH];
   logic [TIME_W-1:0]   slot_time_ff [TABLE_DEPTH];

   logic                advance, accept, csr_write;
   slot_mask_type       live, match, free, ins_onehot;
   logic [TIME_W:0]     expiry [TABLE_DEPTH];
   logic [CNT_W-1:0]    count;
   logic                limited, any_free, admit;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_LIMIT:  limit_ff  <= csr_pwdata[LIMIT_W-1:0];
            CSR_IDX_WINDOW: window_ff <= csr_pwdata[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_LIMIT:  csr_prdata = CSR_DATA_W'(limit_ff);
         CSR_IDX_WINDOW: csr_prdata = CSR_DATA_W'(window_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_ff <= req_client_key;
         s1_now_ff <= req_now_seconds;
      end
      if (advance) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   // ---------------- table lookup and decision ----------------
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         // Expiry is one bit wider than a timestamp so the sum cannot wrap.
         expiry[i] = {1'b0, slot_time_ff[i]} + (TIME_W + 1)'(window_ff);
         live[i]   = slot_valid_ff[i] && !(expiry[i] < {1'b0, s1_now_ff});
         match[i]  = live[i] && (slot_key_ff[i] == s1_key_ff);
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         count = count + CNT_W'(match[i]);
      end
   end

   // The lowest free slot is isolated by the two's complement trick.
   assign free       = ~live;
   assign ins_onehot = free & (~free + slot_mask_type'(1));
   assign any_free   = |free;
   assign limited    = CMP_W'(count) >= CMP_W'(limit_ff);
   assign admit      = !limited && any_free;

   always_comb begin
      if (limited) begin
         rsp_verdict_in = VERDICT_LIMITED;
      end else if (any_free) begin
         rsp_verdict_in = VERDICT_ADMITTED;
      end else begin
         rsp_verdict_in = VERDICT_FULL;
      end

      if (count > CNT_W'(COUNT_MAX)) begin
         rsp_count_in = COUNT_W'(COUNT_MAX);
      end else begin
         rsp_count_in = count[COUNT_W-1:0];
      end

      slot_valid_in = live | (admit ? ins_onehot : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (advance && admit && ins_onehot[i]) begin
            slot_key_ff[i]  <= s1_key_ff;
            slot_time_ff[i] <= s1_now_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_recent_count = rsp_count_ff;

endmodule

// ----- design/swrl_checker.sv -----
`timescale 1ns / 1ps
`include "sliding_window_rate_limiter_assert.svh"

module swrl_checker
   import swrl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [VERDICT_W-1:0]  rsp_verdict,
   input logic [COUNT_W-1:0]    rsp_recent_count
);

   // A stalled response word must stay offered.
   `SWRL_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "response word dropped while stalled")

   // Reset leaves both the input register and the response register empty.
   `SWRL_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

   `SWRL_ASSERT_CLK(a_verdict_code, clock, reset, rsp_valid |-> (rsp_verdict == VERDICT_ADMITTED || rsp_verdict == VERDICT_LIMITED || rsp_verdict == VERDICT_FULL), "undefined verdict code")

   // An admitted word needed a free slot, so not every slot can have matched.
   `SWRL_ASSERT_CLK(a_admit_count, clock, reset, rsp_valid && rsp_verdict == VERDICT_ADMITTED |-> 32'(rsp_recent_count) < TABLE_DEPTH, "admitted with a full table of matches")

   // The input side can only stall while a response is waiting to be taken.
   `SWRL_ASSERT_CLK(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "request stalled without a stalled response")

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (.*);

// ----- test/sliding_window_rate_limiter_test.sv -----
`timescale 1ns / 1ps

module sliding_window_rate_limiter_test;
   import swrl_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = 3'd4;
   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 160;
   localparam int OPENING_COUNT    = 26;

   typedef struct packed {
      verdict_type          verdict;
      logic [COUNT_W-1:0]   recent_count;
   } verdict_word_type;

   typedef struct {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now_s;
      bit                typed;
      verdict_word_type  word;
   } probe_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KEY_W-1:0]      req_client_key = '0;
   logic [TIME_W-1:0]     req_now_seconds = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VERDICT_W-1:0]  rsp_verdict;
   logic [COUNT_W-1:0]    rsp_recent_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the block's configuration and slot table.
   logic [LIMIT_W-1:0]    cfg_limit = LIMIT_RESET;
   logic [WINDOW_W-1:0]   cfg_window = WINDOW_RESET;
   bit                    slot_live [TABLE_DEPTH] = '{default: 1'b0};
   logic [KEY_W-1:0]      slot_owner [TABLE_DEPTH];
   logic [TIME_W-1:0]     slot_stamp [TABLE_DEPTH];

   verdict_word_type      expected_words [$];
   int                    error_count = 0;
   bit                    idle_on = 1'b1;
   logic [TIME_W-1:0]     clock_now;
   logic [KEY_W-1:0]      key_pool [4];

   // After reset: limit 3, window 60 seconds.
   probe_type opening_probes [OPENING_COUNT] = '{
      '{32'h0000_0000, 32'd0,          1'b1, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0000, 32'd0,          1'b1, '{VERDICT_ADMITTED, 5'd1}},
      '{32'h0000_0000, 32'd0,          1'b1, '{VERDICT_ADMITTED, 5'd2}},
      '{32'h0000_0000, 32'd60,         1'b1, '{VERDICT_LIMITED,  5'd3}},
      '{32'h0000_0000, 32'd61,         1'b1, '{VERDICT_ADMITTED, 5'd0}},
      '{32'hFFFF_FFFF, 32'd61,         1'b1, '{VERDICT_ADMITTED, 5'd0}},
      '{32'hFFFF_FFFF, 32'd61,         1'b1, '{VERDICT_ADMITTED, 5'd1}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, '{VERDICT_ADMITTED, 5'd0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, '{VERDICT_ADMITTED, 5'd1}},
      '{32'hFFFF_FFFF, 32'd0,          1'b1, '{VERDICT_ADMITTED, 5'd2}},
      '{32'hFFFF_FFFF, 32'd0,          1'b1, '{VERDICT_LIMITED,  5'd3}},
      '{32'h0000_0001, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0002, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0003, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0004, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0005, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0006, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0007, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0008, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_0009, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_000A, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_000B, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_000C, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_000D, 32'd0,          1'b0, '{VERDICT_ADMITTED, 5'd0}},
      '{32'h0000_000E, 32'd0,          1'b1, '{VERDICT_FULL,     5'd0}},
      '{32'hFFFF_FFFF, 32'd0,          1'b1, '{VERDICT_LIMITED,  5'd3}}
   };

   logic [LIMIT_W-1:0]  phase_limits  [PHASE_COUNT] = '{8'd3, 8'd0, 8'd255, 8'd1,
                                                         8'd5, 8'd16, 8'd2, 8'd0};
   logic [WINDOW_W-1:0] phase_windows [PHASE_COUNT] = '{16'd60, 16'd10, 16'd65535, 16'd0,
                                                         16'd20, 16'd5, 16'd1000, 16'd0};

   sliding_window_rate_limiter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_client_key   (req_client_key),
      .req_now_seconds  (req_now_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_verdict      (rsp_verdict),
      .rsp_recent_count (rsp_recent_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Purge, count and insert for one request, updating the shadow table.
   function automatic verdict_word_type admit_request(input logic [KEY_W-1:0] key,
                                                      input logic [TIME_W-1:0] now_s);
      logic [TIME_W:0]  expiry;
      int unsigned      hit_count;
      bit               placed;
      verdict_word_type word;
      hit_count = 0;
      placed = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         expiry = (TIME_W + 1)'(slot_stamp[i]) + (TIME_W + 1)'(cfg_window);
         if (slot_live[i] && expiry < (TIME_W + 1)'(now_s)) slot_live[i] = 1'b0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i] && slot_owner[i] == key) hit_count++;
      end
      if (hit_count >= cfg_limit) begin
         word.verdict = VERDICT_LIMITED;
      end else begin
         word.verdict = VERDICT_FULL;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!placed && !slot_live[i]) begin
               slot_live[i] = 1'b1;
               slot_owner[i] = key;
               slot_stamp[i] = now_s;
               word.verdict = VERDICT_ADMITTED;
               placed = 1'b1;
            end
         end
      end
      word.recent_count = (hit_count > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(hit_count);
      return word;
   endfunction

   // Called right after a rising edge; returns right after the edge that took the word.
   task automatic send_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now_s,
                               input bit typed, input verdict_word_type typed_word);
      int               gap;
      verdict_word_type predicted;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_client_key <= key;
      req_now_seconds <= now_s;
      do @(posedge clock); while (req_stall);
      predicted = admit_request(key, now_s);
      expected_words.push_back(typed ? typed_word : predicted);
   endtask

   task automatic drain_responses;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write one register, then read it back once the bus is idle again.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_pready !== 1'b1) begin
         $error("csr_pready: expected 1, got %0b", csr_pready);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (addr)
         LIMIT_ADDR: cfg_limit = data[LIMIT_W-1:0];
         WINDOW_ADDR: cfg_window = data[WINDOW_W-1:0];
         default: ;
      endcase
      readback = (addr == LIMIT_ADDR) ? CSR_DATA_W'(cfg_limit) : CSR_DATA_W'(cfg_window);
      @(posedge clock);
      if (csr_prdata !== readback) begin
         $error("csr_prdata: expected %0d, got %0d", readback, csr_prdata);
         error_count++;
      end
   endtask

   // Time mostly creeps forward; now and then it leaps or jumps anywhere.
   task automatic advance_clock_now;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
      end else if (pick < 90) begin
         clock_now = clock_now + $urandom_range(0, (cfg_window >> 3) + 1);
      end else if (pick < 98) begin
         clock_now = clock_now + $urandom_range(0, 2 * cfg_window + 2);
      end else begin
         clock_now = $urandom;
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_key;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return key_pool[0];
      if (pick < 85) return key_pool[$urandom_range(1, 3)];
      return $urandom;
   endfunction

   // Receiver: a random stall before each word, except in idle-free stretches.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = idle_on ? $urandom_range(0, 3) : 0;
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      verdict_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("response word with no request pending");
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_verdict);
               error_count++;
            end
            if (rsp_recent_count !== want.recent_count) begin
               $error("recent_count: expected %0d, got %0d", want.recent_count,
                      rsp_recent_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [LIMIT_W-1:0]  limit_value;
      logic [WINDOW_W-1:0] window_value;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_probes[i]) begin
         send_request(opening_probes[i].key, opening_probes[i].now_s,
                      opening_probes[i].typed, opening_probes[i].word);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Registers change only with the pipeline empty.
         drain_responses();
         limit_value = phase_limits[phase];
         window_value = phase_windows[phase];
         if (phase == PHASE_COUNT - 1) begin
            limit_value = $urandom_range(0, 255);
            window_value = $urandom_range(0, 65535);
         end
         write_csr(LIMIT_ADDR, CSR_DATA_W'(limit_value));
         write_csr(WINDOW_ADDR, CSR_DATA_W'(window_value));
         foreach (key_pool[k]) key_pool[k] = $urandom;
         key_pool[3] = phase[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         clock_now = (phase == 2) ? 32'hFFFF_FF00 : $urandom;
         idle_on = (phase % 3 != 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            advance_clock_now();
            send_request(pick_key(), clock_now, 1'b0, '0);
         end
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
